FILE: sv/hsa_pkg.sv
package hsa_pkg;

    // pixel channel width and channel count
    localparam int ChanW   = 8;
    localparam int NumChan = 3;

    // gain divider: unsigned Q8.16 quotient, three quotient bits per stage
    localparam int FracW     = 16;
    localparam int QuotW     = 24;
    localparam int DivBits   = 3;
    localparam int DivStages = QuotW / DivBits;

    // percent limits
    localparam logic signed [7:0] PctMax = 8'sd100;
    localparam logic signed [7:0] PctMin = -8'sd100;

    // desaturate path: t / 200 by reciprocal multiply, valid for t below 256 * 200
    localparam logic [16:0] RecipMul   = 17'd83887;
    localparam int          RecipShift = 24;
    localparam logic [16:0] NegLimit   = 17'd51200;

    // item side data carried alongside the divider
    typedef struct packed {
        logic [NumChan-1:0][ChanW-1:0] ch;
        logic [8:0]                    sum;
        logic                          neg;
        logic                          gray;
        logic [6:0]                    padd;   // 100 + percent for the desaturate path
    } t_item;

    typedef struct packed {
        logic [ChanW-1:0]   rem;
        logic [DivBits-1:0] q;
    } t_div_step;

    // restoring division, DivBits bits of the quotient
    function automatic t_div_step div_step(input logic [ChanW-1:0]   rem,
                                           input logic [ChanW-1:0]   den,
                                           input logic [DivBits-1:0] nbits);
        t_div_step  res;
        logic [8:0] r9;
        res.rem = rem;
        res.q   = '0;
        for (int b = DivBits - 1; b >= 0; b--) begin
            r9 = {res.rem, nbits[b]};
            if (r9 >= {1'b0, den}) begin
                r9       = r9 - {1'b0, den};
                res.q[b] = 1'b1;
            end
            res.rem = r9[ChanW-1:0];
        end
        return res;
    endfunction

endpackage

FILE: sv/hsa_divider.sv
module hsa_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [hsa_pkg::ChanW-1:0] i_num,
    input  logic [hsa_pkg::ChanW-1:0] i_den,
    input  hsa_pkg::t_item            i_item,
    output logic                      o_valid,
    output logic [hsa_pkg::QuotW-1:0] o_quot,
    output hsa_pkg::t_item            o_item
);

    localparam int NS = hsa_pkg::DivStages;
    localparam int NB = hsa_pkg::DivBits;

    logic                      r_v    [NS];
    logic [hsa_pkg::ChanW-1:0] r_rem  [NS];
    logic [hsa_pkg::ChanW-1:0] r_num  [NS];
    logic [hsa_pkg::ChanW-1:0] r_den  [NS];
    logic [hsa_pkg::QuotW-1:0] r_quot [NS];
    hsa_pkg::t_item            r_item [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        localparam int Hi = hsa_pkg::QuotW - 1 - NB * k;

        logic                      p_v;
        logic [hsa_pkg::ChanW-1:0] p_rem;
        logic [hsa_pkg::ChanW-1:0] p_num;
        logic [hsa_pkg::ChanW-1:0] p_den;
        logic [hsa_pkg::QuotW-1:0] p_quot;
        hsa_pkg::t_item            p_item;
        logic [hsa_pkg::QuotW-1:0] n_dividend;
        hsa_pkg::t_div_step        n_step;
        logic [hsa_pkg::QuotW-1:0] n_quot;

        if (k == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_rem  = '0;
            assign p_num  = i_num;
            assign p_den  = i_den;
            assign p_quot = '0;
            assign p_item = i_item;
        end else begin : g_next
            assign p_v    = r_v[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_num  = r_num[k-1];
            assign p_den  = r_den[k-1];
            assign p_quot = r_quot[k-1];
            assign p_item = r_item[k-1];
        end

        // dividend is num << 16
        assign n_dividend = {p_num, {hsa_pkg::FracW{1'b0}}};
        assign n_step     = hsa_pkg::div_step(p_rem, p_den, n_dividend[Hi -: NB]);

        always_comb begin
            n_quot          = p_quot;
            n_quot[Hi -: NB] = n_step.q;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_step.rem;
                r_num[k]  <= p_num;
                r_den[k]  <= p_den;
                r_quot[k] <= n_quot;
                r_item[k] <= p_item;
            end
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_quot  = r_quot[NS-1];
    assign o_item  = r_item[NS-1];

endmodule

FILE: sv/hsa_channel.sv
module hsa_channel (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [hsa_pkg::ChanW-1:0] i_ch,
    input  logic [8:0]                i_sum,
    input  logic                      i_neg,
    input  logic                      i_gray,
    input  logic [hsa_pkg::QuotW-1:0] i_factor,
    output logic [hsa_pkg::ChanW-1:0] o_ch
);

    // stage A: (2C - sum) * factor
    logic signed [10:0] n_d;
    logic signed [35:0] n_prod;
    logic signed [35:0] r_prod;
    logic [7:0]         r_cha;
    logic [8:0]         r_suma;
    logic               r_nega;
    logic               r_graya;

    assign n_d    = $signed({2'b00, i_ch, 1'b0}) - $signed({2'b00, i_sum});
    assign n_prod = n_d * $signed({1'b0, i_factor});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= n_prod;
            r_cha   <= i_ch;
            r_suma  <= i_sum;
            r_nega  <= i_neg;
            r_graya <= i_gray;
        end
    end

    // stage B: add the base term
    logic signed [37:0] n_t;
    logic signed [37:0] r_t;
    logic [7:0]         r_chb;
    logic               r_negb;
    logic               r_grayb;
    logic [15:0]        n_base100;

    assign n_base100 = 16'(r_suma) * 16'd100;

    always_comb begin
        if (r_nega) begin
            n_t = $signed({22'd0, n_base100}) + 38'(r_prod);
        end else begin
            n_t = $signed({13'd0, r_cha, 17'd0}) + 38'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t     <= n_t;
            r_chb   <= r_cha;
            r_negb  <= r_nega;
            r_grayb <= r_graya;
        end
    end

    // stage C: scale, clamp, gray bypass
    logic [32:0] n_recip;
    logic [7:0]  n_out;
    logic [7:0]  r_out;

    assign n_recip = 33'(r_t[15:0]) * 33'(hsa_pkg::RecipMul);

    always_comb begin
        if (r_grayb) begin
            n_out = r_chb;
        end else if (r_t <= 38'sd0) begin
            n_out = '0;
        end else if (r_negb) begin
            if (r_t >= $signed({21'd0, hsa_pkg::NegLimit})) begin
                n_out = 8'hFF;
            end else begin
                n_out = n_recip[hsa_pkg::RecipShift +: 8];
            end
        end else if (r_t[37:25] != '0) begin
            n_out = 8'hFF;
        end else begin
            n_out = r_t[24:17];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_ch = r_out;

endmodule

FILE: sv/hsl_saturation_adjust.sv
// HSL saturation adjust, one BGR pixel per beat.
// Pipeline from input beat to output beat: 1 input stage, 8 divider stages of 3 quotient
// bits each, 3 channel stages for multiply, sum and clamp.
// Throughput: one pixel per cycle; an output stall holds the whole pipeline.
// Reset (i_rst_n low, synchronous) clears all valid bits and sets the percent to 0.
module hsl_saturation_adjust (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,  // saturation_percent, signed
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,    // blue_in [7:0], green_in [15:8], red_in [23:16]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata     // blue_out [7:0], green_out [15:8], red_out [23:16]
);

    localparam int NC = hsa_pkg::NumChan;

    logic en;

    // percent register
    logic signed [7:0] r_pct;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pct <= '0;
        end else if (i_cfg_we) begin
            r_pct <= i_cfg_wdata;
        end
    end

    // stage 1: max / min, clamped percent
    logic [7:0]        n_b, n_g, n_r, n_mx, n_mn;
    logic signed [7:0] n_p;
    logic              r_v1;
    logic [NC-1:0][7:0] r_ch1;
    logic [7:0]        r_mx1, r_mn1;
    logic signed [7:0] r_p1;

    assign n_b = i_s_tdata[7:0];
    assign n_g = i_s_tdata[15:8];
    assign n_r = i_s_tdata[23:16];

    always_comb begin
        n_mx = n_b;
        n_mn = n_b;
        if (n_g > n_mx) n_mx = n_g;
        if (n_r > n_mx) n_mx = n_r;
        if (n_g < n_mn) n_mn = n_g;
        if (n_r < n_mn) n_mn = n_r;
        if (r_pct > hsa_pkg::PctMax) begin
            n_p = hsa_pkg::PctMax;
        end else if (r_pct < hsa_pkg::PctMin) begin
            n_p = hsa_pkg::PctMin;
        end else begin
            n_p = r_pct;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ch1 <= {n_r, n_g, n_b};
            r_mx1 <= n_mx;
            r_mn1 <= n_mn;
            r_p1  <= n_p;
        end
    end

    // stage 2: saturation, branch select, divider operands
    logic [7:0]     n_delta, n_denom, n_num, n_den;
    logic [8:0]     n_sum;
    logic [15:0]    n_pden, n_dlt100, n_den100;
    logic [16:0]    n_lhs;
    logic           n_neg, n_sel_s;
    hsa_pkg::t_item n_item;

    always_comb begin
        n_delta  = r_mx1 - r_mn1;
        n_sum    = {1'b0, r_mx1} + {1'b0, r_mn1};
        n_denom  = (n_sum < 9'd255) ? n_sum[7:0] : 8'(9'd510 - n_sum);
        n_neg    = r_p1[7];
        n_pden   = 16'(r_p1[6:0]) * 16'(n_denom);
        n_dlt100 = 16'(n_delta) * 16'd100;
        n_den100 = 16'(n_denom) * 16'd100;
        n_lhs    = 17'(n_pden) + 17'(n_dlt100);
        n_sel_s  = n_lhs >= 17'(n_den100);
        if (n_sel_s) begin
            n_num = n_denom - n_delta;
            n_den = n_delta;
        end else begin
            n_num = {1'b0, r_p1[6:0]};
            n_den = 8'd100 - {1'b0, r_p1[6:0]};
        end
        n_item.ch   = r_ch1;
        n_item.sum  = n_sum;
        n_item.neg  = n_neg;
        n_item.gray = (n_delta == 8'd0);
        n_item.padd = 7'(8'sd100 + r_p1);
    end

    logic                      dv_valid;
    logic [hsa_pkg::QuotW-1:0] dv_quot;
    hsa_pkg::t_item            dv_item;

    hsa_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v1),
        .i_num   (n_num),
        .i_den   (n_den),
        .i_item  (n_item),
        .o_valid (dv_valid),
        .o_quot  (dv_quot),
        .o_item  (dv_item)
    );

    // per-channel multiply, add and clamp
    logic [hsa_pkg::QuotW-1:0] factor;
    assign factor = dv_item.neg ? hsa_pkg::QuotW'(dv_item.padd) : dv_quot;

    for (genvar c = 0; c < NC; c++) begin : g_chan
        hsa_channel u_chan (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_ch     (dv_item.ch[c]),
            .i_sum    (dv_item.sum),
            .i_neg    (dv_item.neg),
            .i_gray   (dv_item.gray),
            .i_factor (factor),
            .o_ch     (o_m_tdata[c*8 +: 8])
        );
    end

    // valid bits for the channel stages
    logic [2:0] r_vc;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= '0;
        end else if (en) begin
            r_vc <= {r_vc[1:0], dv_valid};
        end
    end

    assign o_m_tvalid = r_vc[2];
    assign en         = !r_vc[2] || i_m_tready;
    assign o_s_tready = en;

endmodule
